/* rtl/core/fixed_point_alu_defines.svh */
// Assertion helpers for the fixed-point ALU.
// Each macro expects clk and rst in scope at the point of use.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/fpa_pkg.sv */
package fpa_pkg;

  typedef enum logic [3:0] {
    FUNC_ADD      = 4'd0,
    FUNC_SUB      = 4'd1,
    FUNC_MUL      = 4'd2,
    FUNC_DIV      = 4'd3,
    FUNC_GT       = 4'd4,
    FUNC_GE       = 4'd5,
    FUNC_LT       = 4'd6,
    FUNC_LE       = 4'd7,
    FUNC_EQ       = 4'd8,
    FUNC_NE       = 4'd9,
    FUNC_MIN      = 4'd10,
    FUNC_MAX      = 4'd11,
    FUNC_INC      = 4'd12,
    FUNC_DEC      = 4'd13,
    FUNC_TO_INT   = 4'd14,
    FUNC_FROM_INT = 4'd15
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    logic    cmp;
    status_t stat;
  } flags_t;

endpackage

/* rtl/core/fpa_simple.sv */
// Combinational operations: add/sub/inc/dec with saturation, compares,
// min/max and the integer conversions. Multiply and divide pass through as zero.
module fpa_simple #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  fpa_pkg::func_t              func,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic [DATA_WIDTH-1:0]        res,
  output fpa_pkg::flags_t              flg
);

  localparam int DW = DATA_WIDTH;
  localparam int XW = DATA_WIDTH + FRAC_BITS;
  localparam logic [DW-1:0] MaxPos = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MinNeg = {1'b1, {(DW-1){1'b0}}};

  logic [DW:0]   sum, dif, incv, decv;
  logic          lt_ab, lt_ba;
  logic [DW-1:0] mag_a, fi_val;
  logic [XW-1:0] fi_mag, fi_lim;
  logic          fi_sat;

  function automatic logic [DW-1:0] clamp(input logic [DW:0] v);
    logic ovf;
    ovf = v[DW] ^ v[DW-1];
    if (ovf) begin
      return v[DW] ? MinNeg : MaxPos;
    end
    return v[DW-1:0];
  endfunction

  assign sum   = {a[DW-1], a} + {b[DW-1], b};
  assign dif   = {a[DW-1], a} - {b[DW-1], b};
  assign incv  = {a[DW-1], a} + (DW+1)'(1);
  assign decv  = {a[DW-1], a} - (DW+1)'(1);
  assign lt_ab = a < b;
  assign lt_ba = b < a;

  // from_int: scale the magnitude up, clamp against the signed limit
  assign mag_a  = a[DW-1] ? ~a + DW'(1) : a;
  assign fi_mag = {mag_a, {FRAC_BITS{1'b0}}};
  assign fi_lim = XW'(MaxPos) + XW'(a[DW-1]);
  assign fi_sat = fi_mag > fi_lim;
  assign fi_val = fi_sat ? fi_lim[DW-1:0] : fi_mag[DW-1:0];

  always_comb begin
    res      = '0;
    flg.cmp  = 1'b0;
    flg.stat = fpa_pkg::STAT_OK;
    case (func) inside
      fpa_pkg::FUNC_ADD: begin
        res = clamp(sum);
        if (sum[DW] ^ sum[DW-1]) flg.stat = fpa_pkg::STAT_SAT;
      end
      fpa_pkg::FUNC_SUB: begin
        res = clamp(dif);
        if (dif[DW] ^ dif[DW-1]) flg.stat = fpa_pkg::STAT_SAT;
      end
      fpa_pkg::FUNC_INC: begin
        res = clamp(incv);
        if (incv[DW] ^ incv[DW-1]) flg.stat = fpa_pkg::STAT_SAT;
      end
      fpa_pkg::FUNC_DEC: begin
        res = clamp(decv);
        if (decv[DW] ^ decv[DW-1]) flg.stat = fpa_pkg::STAT_SAT;
      end
      fpa_pkg::FUNC_MUL, fpa_pkg::FUNC_DIV: res = '0;
      fpa_pkg::FUNC_GT: flg.cmp = lt_ba;
      fpa_pkg::FUNC_GE: flg.cmp = !lt_ab;
      fpa_pkg::FUNC_LT: flg.cmp = lt_ab;
      fpa_pkg::FUNC_LE: flg.cmp = !lt_ba;
      fpa_pkg::FUNC_EQ: flg.cmp = (a == b);
      fpa_pkg::FUNC_NE: flg.cmp = (a != b);
      fpa_pkg::FUNC_MIN: res = lt_ab ? a : b;
      fpa_pkg::FUNC_MAX: res = lt_ba ? a : b;
      fpa_pkg::FUNC_TO_INT: res = a >>> FRAC_BITS;
      fpa_pkg::FUNC_FROM_INT: begin
        res = a[DW-1] ? ~fi_val + DW'(1) : fi_val;
        if (fi_sat) flg.stat = fpa_pkg::STAT_SAT;
      end
      default: res = '0;
    endcase
  end

endmodule

/* rtl/core/fixed_point_alu.sv */
// Channel  Handshake            Payload
// op       op_valid/op_ready    func, operand_a, operand_b
// res      res_valid/res_ready  result_value, compare_true, status
//
// One operation enters per cycle while op_ready is high. The pipeline holds
// DATA_WIDTH + FRAC_BITS + 4 stages (44 at the defaults).
// The depth is set by the divider, which retires one quotient bit per stage.
// All operations pass through every stage, so results keep input order.
// rst (synchronous) empties the pipeline. A stalled output freezes occupied stages while
// items still close up into empty ones; op_ready is then high only while stage 0 is empty.
`include "fixed_point_alu_defines.svh"

module fixed_point_alu #(
  parameter int FRAC_BITS  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  logic [3:0]         func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] result_value,
  output logic               compare_true,
  output logic [1:0]         status
);

  localparam int DW = DATA_WIDTH;
  localparam int QW = DATA_WIDTH + FRAC_BITS;          // quotient bits
  localparam int L  = QW + 4;                          // pipeline stages
  localparam int H  = (DATA_WIDTH + 1) / 2;            // low half of a multiplier split
  localparam int RW = 2 * DATA_WIDTH + 1;
  localparam int MW = (RW > QW + 1) ? RW : QW + 1;     // pre-saturation magnitude
  localparam logic [DW-1:0] MaxPos = {1'b0, {(DW-1){1'b1}}};
  localparam logic [RW-1:0] Half   = RW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    fpa_pkg::func_t      func;
    logic [DW-1:0]       a;
    logic [DW-1:0]       b;
    logic                neg;
    logic                div0;
    logic [DW-1:0]       x;
    logic [DW-1:0]       d;
    logic [DW-1:0]       res;
    logic [DW-1:0]       rem;
    logic [DW-1:0]       pt;
    fpa_pkg::flags_t     flg;
    logic [QW-1:0]       nq;
    logic [2*DW-1:0]     acc;
    logic [MW-1:0]       mg;
  } stage_t;

  stage_t     st      [L];
  stage_t     st_next [L];
  logic [L-1:0] vld, vld_next, adv, nadv, pv;
  logic         en;

  // Occupied stages move together on en; an empty stage always pulls.
  assign en       = !vld[L-1] || res_ready;
  assign adv      = {L{en}} | ~vld;
  assign nadv     = {1'b0, adv[L-1:1]};
  assign pv       = {vld[L-2:0], op_valid};
  assign vld_next = (adv & pv) | (~adv & vld & ~nadv);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      if (adv[i]) st[i] <= st_next[i];
    end
  end

  for (genvar s = 0; s < L; s++) begin : g_stage
    if (s == 0) begin : g_in
      always_comb begin
        st_next[0]      = '0;
        st_next[0].func = fpa_pkg::func_t'(func);
        st_next[0].a    = DW'(operand_a);
        st_next[0].b    = DW'(operand_b);
      end
    end else if (s == 1) begin : g_prep
      logic [DW-1:0]   simple_res;
      fpa_pkg::flags_t simple_flg;

      fpa_simple #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FRAC_BITS)
      ) u_simple (
        .func(st[0].func),
        .a   (st[0].a),
        .b   (st[0].b),
        .res (simple_res),
        .flg (simple_flg)
      );

      always_comb begin
        st_next[1]      = st[0];
        st_next[1].res  = simple_res;
        st_next[1].flg  = simple_flg;
        st_next[1].neg  = st[0].a[DW-1] ^ st[0].b[DW-1];
        st_next[1].div0 = (st[0].b == '0);
        st_next[1].x    = st[0].a[DW-1] ? ~st[0].a + DW'(1) : st[0].a;
        st_next[1].d    = st[0].b[DW-1] ? ~st[0].b + DW'(1) : st[0].b;
        st_next[1].nq   = {st_next[1].x, {FRAC_BITS{1'b0}}};
        st_next[1].rem  = '0;
        st_next[1].pt   = '0;
        st_next[1].acc  = '0;
        st_next[1].mg   = '0;
      end
    end else if (s <= QW + 1) begin : g_div
      logic [2*DW-1:0] prod;
      logic [DW:0]     trial;
      logic            take;

      // Magnitude product in four partial products, one per stage.
      if (s == 2) begin : g_ll
        assign prod = (2*DW)'(st[s-1].x[H-1:0] * st[s-1].d[H-1:0]);
      end else if (s == 3) begin : g_hh
        assign prod = (2*DW)'(st[s-1].x[DW-1:H] * st[s-1].d[DW-1:H]);
      end else if (s == 4) begin : g_lh
        assign prod = (2*DW)'(st[s-1].x[H-1:0] * st[s-1].d[DW-1:H]);
      end else if (s == 5) begin : g_hl
        assign prod = (2*DW)'(st[s-1].x[DW-1:H] * st[s-1].d[H-1:0]);
      end else begin : g_none
        assign prod = '0;
      end

      // Restoring division step: shift in one numerator bit, retire one quotient bit.
      assign trial = {st[s-1].rem, st[s-1].nq[QW-1]};
      assign take  = trial >= {1'b0, st[s-1].d};

      always_comb begin
        st_next[s]     = st[s-1];
        st_next[s].rem = take ? DW'(trial - {1'b0, st[s-1].d}) : trial[DW-1:0];
        st_next[s].nq  = {st[s-1].nq[QW-2:0], take};
        if (s == 2) begin
          st_next[s].acc = prod;
        end else if (s == 3) begin
          st_next[s].acc = st[s-1].acc | (prod << (2 * H));
        end else if (s == 4) begin
          st_next[s].pt = prod[DW-1:0];
        end else if (s == 5) begin
          st_next[s].acc = st[s-1].acc + ((2*DW)'(st[s-1].pt) << H);
          st_next[s].pt  = prod[DW-1:0];
        end else if (s == 6) begin
          st_next[s].acc = st[s-1].acc + ((2*DW)'(st[s-1].pt) << H);
        end
      end
    end else if (s == QW + 2) begin : g_round
      logic [RW-1:0] rsum;
      logic          rbit;

      // Round half away from zero on the magnitude.
      assign rsum = {1'b0, st[s-1].acc} + Half;
      assign rbit = {st[s-1].rem, 1'b0} >= {1'b0, st[s-1].d};

      always_comb begin
        st_next[s] = st[s-1];
        if (st[s-1].func == fpa_pkg::FUNC_MUL) begin
          st_next[s].mg = MW'(rsum >> FRAC_BITS);
        end else begin
          st_next[s].mg = MW'(st[s-1].nq) + MW'(rbit);
        end
      end
    end else begin : g_pack
      logic [DW-1:0] lim, mv, sv;
      logic          sat;

      assign lim = MaxPos + DW'(st[s-1].neg);
      assign sat = st[s-1].mg > MW'(lim);
      assign mv  = sat ? lim : st[s-1].mg[DW-1:0];
      assign sv  = st[s-1].neg ? ~mv + DW'(1) : mv;

      always_comb begin
        st_next[s] = st[s-1];
        if (st[s-1].func == fpa_pkg::FUNC_MUL) begin
          st_next[s].res      = sv;
          st_next[s].flg.stat = sat ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
        end else if (st[s-1].func == fpa_pkg::FUNC_DIV) begin
          if (st[s-1].div0) begin
            st_next[s].res      = '0;
            st_next[s].flg.stat = fpa_pkg::STAT_DIV0;
          end else begin
            st_next[s].res      = sv;
            st_next[s].flg.stat = sat ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
          end
        end
      end
    end
  end

  assign op_ready     = adv[0];
  assign res_valid    = vld[L-1];
  assign result_value = 32'($signed(st[L-1].res));
  assign compare_true = st[L-1].flg.cmp;
  assign status       = st[L-1].flg.stat;

  `FPA_ASSERT_IMP(a_ready_when_drained, res_ready, op_ready, "op_ready low while output drains")
  `FPA_ASSERT_NXT(a_accept_lands, op_valid && op_ready, vld[0], "accepted transaction lost at entry")
  `FPA_ASSERT_IMP(a_div0_zero, res_valid && status == fpa_pkg::STAT_DIV0, result_value == '0 && !compare_true, "divide by zero result not cleared")
  `FPA_ASSERT_IMP(a_cmp_clean, res_valid && compare_true, status == fpa_pkg::STAT_OK && result_value == '0, "compare result carries value or status")

endmodule
